>>> rtl/core/mrr_pkg.sv
// ----------------------------------------------------------------------------
// mrr_pkg
// Shared types and constants for the matrix ring rotation block.
// ----------------------------------------------------------------------------
package mrr_pkg;

  localparam int MAX_DIM_DEF    = 16;
  localparam int DATA_WIDTH_DEF = 32;

  localparam int CMD_W     = 2;
  localparam int COORD_W   = 4;
  localparam int VALUE_W   = 32;
  localparam int RING_W    = 4;
  localparam int SHIFT_W   = 16;
  localparam int STATUS_W  = 2;
  localparam int CFG_W     = 5;
  localparam int CFG_IDX_W = 1;

  localparam logic [CFG_W-1:0] DIM_RESET = 5'd16;

  localparam logic [CMD_W-1:0] CMD_WRITE  = 2'd0;
  localparam logic [CMD_W-1:0] CMD_ROTATE = 2'd1;
  localparam logic [CMD_W-1:0] CMD_READ   = 2'd2;

  localparam logic [STATUS_W-1:0] ST_OK        = 2'd0;
  localparam logic [STATUS_W-1:0] ST_BAD_COORD = 2'd1;
  localparam logic [STATUS_W-1:0] ST_BAD_RING  = 2'd2;

  localparam logic [CFG_IDX_W-1:0] CFG_ROW_COUNT    = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_COLUMN_COUNT = 1'd1;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DIV,
    ST_LOAD,
    ST_REWIND,
    ST_STORE,
    ST_RESP
  } mrr_state_t;

  // controller to datapath
  typedef struct packed {
    logic accept;
    logic div_step;
    logic load_step;
    logic rewind;
    logic store_step;
    logic resp_load;
  } mrr_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic rot_go;
    logic div_done;
    logic walk_last;
  } mrr_stat_t;

endpackage

>>> rtl/core/mrr_ctrl.sv
// ----------------------------------------------------------------------------
// mrr_ctrl
// Sequencer for the matrix ring rotation block: accept, modulo, two ring
// passes and result hand-off.
// ----------------------------------------------------------------------------
module mrr_ctrl
  import mrr_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_ready,
  output logic      out_valid,
  input  logic      out_ready,
  input  mrr_stat_t stat,
  output mrr_cmd_t  cmd
);

  mrr_state_t state_r, state_nxt;
  logic       out_valid_r, out_valid_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_ready  = 1'b0;
    case (state_r)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.accept = 1'b1;
          state_nxt  = stat.rot_go ? ST_DIV : ST_RESP;
        end
      end
      ST_DIV: begin
        cmd.div_step = 1'b1;
        if (stat.div_done) begin
          state_nxt = ST_LOAD;
        end
      end
      ST_LOAD: begin
        cmd.load_step = 1'b1;
        if (stat.walk_last) begin
          state_nxt = ST_REWIND;
        end
      end
      ST_REWIND: begin
        cmd.rewind = 1'b1;
        state_nxt  = ST_STORE;
      end
      ST_STORE: begin
        cmd.store_step = 1'b1;
        if (stat.walk_last) begin
          state_nxt = ST_RESP;
        end
      end
      ST_RESP: begin
        // hold until the output register is free
        if (!out_valid_r || out_ready) begin
          cmd.resp_load = 1'b1;
          state_nxt     = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_comb begin
    if (cmd.resp_load) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  assign out_valid = out_valid_r;

endmodule

>>> rtl/core/mrr_dp.sv
// ----------------------------------------------------------------------------
// mrr_dp
// Datapath: configuration registers, matrix store, ring scratch memory,
// ring walker, shift-modulo unit and result register.
// ----------------------------------------------------------------------------
module mrr_dp
  import mrr_pkg::*;
#(
  parameter int MAX_DIM    = MAX_DIM_DEF,
  parameter int DATA_WIDTH = DATA_WIDTH_DEF
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       cfg_we,
  input  logic [CFG_IDX_W-1:0]       cfg_index,
  input  logic [CFG_W-1:0]           cfg_data,
  input  logic [CMD_W-1:0]           in_command,
  input  logic [COORD_W-1:0]         in_row,
  input  logic [COORD_W-1:0]         in_col,
  input  logic signed [VALUE_W-1:0]  in_value,
  input  logic [RING_W-1:0]          in_ring,
  input  logic signed [SHIFT_W-1:0]  in_shift,
  output logic signed [VALUE_W-1:0]  out_read_value,
  output logic [STATUS_W-1:0]        out_status,
  input  mrr_cmd_t                   cmd,
  output mrr_stat_t                  stat
);

  localparam int RW      = $clog2(MAX_DIM);
  localparam int AW      = $clog2(MAX_DIM * MAX_DIM);
  localparam int DEPTH   = MAX_DIM * MAX_DIM;
  localparam int RDEPTH  = 4 * MAX_DIM;
  localparam int TW      = $clog2(RDEPTH);
  localparam int CW      = ($clog2(MAX_DIM + 1) > CFG_W) ? $clog2(MAX_DIM + 1) : CFG_W;
  localparam int LW      = CW + 3;
  localparam int DCNT_W  = $clog2(SHIFT_W);

  // configuration
  logic [CFG_W-1:0] rows_cfg_r, cols_cfg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rows_cfg_r <= DIM_RESET;
      cols_cfg_r <= DIM_RESET;
    end else if (cfg_we) begin
      if (cfg_index == CFG_ROW_COUNT) begin
        rows_cfg_r <= cfg_data;
      end
      if (cfg_index == CFG_COLUMN_COUNT) begin
        cols_cfg_r <= cfg_data;
      end
    end
  end

  logic [CW-1:0] rows_x, cols_x;

  // clamp counts into 1..MAX_DIM
  always_comb begin
    if (rows_cfg_r == '0) begin
      rows_x = CW'(1);
    end else if (CW'(rows_cfg_r) > CW'(MAX_DIM)) begin
      rows_x = CW'(MAX_DIM);
    end else begin
      rows_x = CW'(rows_cfg_r);
    end
    if (cols_cfg_r == '0) begin
      cols_x = CW'(1);
    end else if (CW'(cols_cfg_r) > CW'(MAX_DIM)) begin
      cols_x = CW'(MAX_DIM);
    end else begin
      cols_x = CW'(cols_cfg_r);
    end
  end

  // accept-time decode
  logic                coord_ok, ring_ok;
  logic [CW-1:0]       twice_s;
  logic [STATUS_W-1:0] acc_status;
  logic                wr_en, rd_acc;
  logic [AW-1:0]       in_addr;
  logic [LW-1:0]       t_full;
  logic [63:0]         val64;

  assign twice_s  = CW'({in_ring, 1'b0});
  assign coord_ok = (CW'(in_row) < rows_x) && (CW'(in_col) < cols_x);
  assign ring_ok  = (in_ring != '0) && (twice_s <= rows_x) && (twice_s <= cols_x);
  assign in_addr  = AW'(RW'(in_row)) * AW'(MAX_DIM) + AW'(RW'(in_col));
  assign t_full   = LW'({rows_x, 1'b0}) + LW'({cols_x, 1'b0}) + LW'(4)
                  - LW'({in_ring, 3'b000});
  assign val64    = {32'b0, in_value};

  always_comb begin
    case (in_command)
      CMD_WRITE, CMD_READ: acc_status = coord_ok ? ST_OK : ST_BAD_COORD;
      CMD_ROTATE:          acc_status = ring_ok ? ST_OK : ST_BAD_RING;
      default:             acc_status = ST_OK;
    endcase
  end

  assign wr_en       = cmd.accept && (in_command == CMD_WRITE) && coord_ok;
  assign rd_acc      = cmd.accept && (in_command == CMD_READ) && coord_ok;
  assign stat.rot_go = (in_command == CMD_ROTATE) && ring_ok;

  // item registers
  logic [STATUS_W-1:0] res_status_r;
  logic                res_is_read_r;
  logic [RW-1:0]       top_r, bottom_r, right_r;
  logic [TW-1:0]       t_r;

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      res_status_r  <= acc_status;
      res_is_read_r <= (in_command == CMD_READ) && coord_ok;
      top_r         <= RW'(in_ring - RING_W'(1));
      bottom_r      <= RW'(rows_x - CW'(in_ring));
      right_r       <= RW'(cols_x - CW'(in_ring));
      t_r           <= TW'(t_full);
    end
  end

  // shift modulo ring length, one bit per cycle
  logic [SHIFT_W-1:0] mag_r;
  logic               neg_r;
  logic [TW-1:0]      rem_r;
  logic [DCNT_W-1:0]  div_cnt_r;
  logic [TW:0]        rem_sh;
  logic [TW-1:0]      idx_start;

  assign rem_sh = {rem_r, mag_r[SHIFT_W-1]};

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      neg_r     <= in_shift[SHIFT_W-1];
      mag_r     <= in_shift[SHIFT_W-1] ? SHIFT_W'(-in_shift) : in_shift;
      rem_r     <= '0;
      div_cnt_r <= '0;
    end else if (cmd.div_step) begin
      mag_r     <= {mag_r[SHIFT_W-2:0], 1'b0};
      rem_r     <= (rem_sh >= {1'b0, t_r}) ? TW'(rem_sh - {1'b0, t_r}) : TW'(rem_sh);
      div_cnt_r <= div_cnt_r + DCNT_W'(1);
    end
  end

  assign stat.div_done = (div_cnt_r == DCNT_W'(SHIFT_W - 1));

  // first source index of the write-back pass: (-shift) mod length
  always_comb begin
    if (neg_r || rem_r == '0) begin
      idx_start = rem_r;
    end else begin
      idx_start = t_r - rem_r;
    end
  end

  // ring walker: down the left column, along the bottom, up the right, back
  // along the top
  logic [RW-1:0] w_row_r, w_col_r;
  logic [TW-1:0] k_r, idx_r;
  logic [AW-1:0] w_addr;
  logic          step;

  assign step           = cmd.load_step || cmd.store_step;
  assign w_addr         = AW'(w_row_r) * AW'(MAX_DIM) + AW'(w_col_r);
  assign stat.walk_last = (k_r == t_r - TW'(1));

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      w_row_r <= RW'(in_ring - RING_W'(1));
      w_col_r <= RW'(in_ring - RING_W'(1));
      k_r     <= '0;
    end else if (cmd.rewind) begin
      w_row_r <= top_r;
      w_col_r <= top_r;
      k_r     <= '0;
      idx_r   <= idx_start;
    end else if (step) begin
      k_r <= k_r + TW'(1);
      if (w_col_r == top_r && w_row_r < bottom_r) begin
        w_row_r <= w_row_r + RW'(1);
      end else if (w_row_r == bottom_r && w_col_r < right_r) begin
        w_col_r <= w_col_r + RW'(1);
      end else if (w_col_r == right_r && w_row_r > top_r) begin
        w_row_r <= w_row_r - RW'(1);
      end else begin
        w_col_r <= w_col_r - RW'(1);
      end
      if (cmd.store_step) begin
        idx_r <= (idx_r == t_r - TW'(1)) ? '0 : idx_r + TW'(1);
      end
    end
  end

  // matrix store
  logic [DATA_WIDTH-1:0] store_mem [DEPTH];
  logic [DATA_WIDTH-1:0] store_q_r;
  logic [AW-1:0]         rd_addr;
  logic                  st_pend_r;
  logic [AW-1:0]         st_addr_r;
  logic [DATA_WIDTH-1:0] ring_q_r;

  assign rd_addr = cmd.load_step ? w_addr : in_addr;

  always_ff @(posedge clk) begin
    if (st_pend_r) begin
      store_mem[st_addr_r] <= ring_q_r;
    end else if (wr_en) begin
      store_mem[in_addr] <= val64[DATA_WIDTH-1:0];
    end
    if (rd_acc || cmd.load_step) begin
      store_q_r <= store_mem[rd_addr];
    end
  end

  // ring scratch memory
  logic [DATA_WIDTH-1:0] ring_mem [RDEPTH];
  logic                  ld_pend_r;
  logic [TW-1:0]         ld_k_r;

  always_ff @(posedge clk) begin
    if (ld_pend_r) begin
      ring_mem[ld_k_r] <= store_q_r;
    end
    if (cmd.store_step) begin
      ring_q_r <= ring_mem[idx_r];
    end
    ld_k_r    <= k_r;
    st_addr_r <= w_addr;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ld_pend_r <= 1'b0;
      st_pend_r <= 1'b0;
    end else begin
      ld_pend_r <= cmd.load_step;
      st_pend_r <= cmd.store_step;
    end
  end

  // result register
  logic [63:0]              rd_ext;
  logic signed [VALUE_W-1:0] out_read_value_r;
  logic [STATUS_W-1:0]      out_status_r;

  always_comb begin
    for (int i = 0; i < 64; i++) begin
      rd_ext[i] = (i < DATA_WIDTH) ? store_q_r[i] : store_q_r[DATA_WIDTH-1];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.resp_load) begin
      out_read_value_r <= res_is_read_r ? rd_ext[VALUE_W-1:0] : '0;
      out_status_r     <= res_status_r;
    end
  end

  assign out_read_value = out_read_value_r;
  assign out_status     = out_status_r;

endmodule

>>> rtl/core/matrix_ring_rotate.sv
// ----------------------------------------------------------------------------
// matrix_ring_rotate
// Matrix of signed words with element write, element read and ring rotate.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid/in_ready) takes one command per transaction:
//   write element, rotate ring or read element. Each transaction yields
//   exactly one result transaction (out_valid/out_ready) with read_value
//   and status.
//   Configuration (cfg_we/cfg_index/cfg_data) sets the rows and columns in
//   use; write it only while the block is idle.
//   Write and read go from acceptance straight to the result state; the next
//   command is taken the cycle after the result is registered. A rotate of
//   a ring of length t runs a bit-serial modulo of the shift, one pass
//   reading the ring into scratch memory, one pass writing it back, each
//   one element per cycle on a single memory port.
//   Rejected commands (bad coordinate, bad ring) go straight to the result.
//   Reset sets both counts to 16 and clears control; matrix contents are
//   undefined until written.
//   When the receiver stalls, the result waits in the output register; one
//   more command is accepted and completed, then the block holds it.
// ----------------------------------------------------------------------------
module matrix_ring_rotate
  import mrr_pkg::*;
#(
  parameter int MAX_DIM    = MAX_DIM_DEF,
  parameter int DATA_WIDTH = DATA_WIDTH_DEF
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       cfg_we,
  input  logic [CFG_IDX_W-1:0]       cfg_index,
  input  logic [CFG_W-1:0]           cfg_data,
  input  logic                       in_valid,
  output logic                       in_ready,
  input  logic [CMD_W-1:0]           in_command,
  input  logic [COORD_W-1:0]         in_row,
  input  logic [COORD_W-1:0]         in_col,
  input  logic signed [VALUE_W-1:0]  in_value,
  input  logic [RING_W-1:0]          in_ring,
  input  logic signed [SHIFT_W-1:0]  in_shift,
  output logic                       out_valid,
  input  logic                       out_ready,
  output logic signed [VALUE_W-1:0]  out_read_value,
  output logic [STATUS_W-1:0]        out_status
);

  mrr_cmd_t  cmd;
  mrr_stat_t stat;

  mrr_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .stat      (stat),
    .cmd       (cmd)
  );

  mrr_dp #(
    .MAX_DIM    (MAX_DIM),
    .DATA_WIDTH (DATA_WIDTH)
  ) u_dp (
    .clk            (clk),
    .rst_n          (rst_n),
    .cfg_we         (cfg_we),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data),
    .in_command     (in_command),
    .in_row         (in_row),
    .in_col         (in_col),
    .in_value       (in_value),
    .in_ring        (in_ring),
    .in_shift       (in_shift),
    .out_read_value (out_read_value),
    .out_status     (out_status),
    .cmd            (cmd),
    .stat           (stat)
  );

endmodule
